>>> hdl/stl_pkg.sv
// shared types and constants of the sta/lta energy trigger
`default_nettype none

package stl_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_WINDOW = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_WINDOW  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD    = 2'd2;

    localparam logic [8:0] SHORT_WINDOW_RST = 9'd2;
    localparam logic [8:0] LONG_WINDOW_RST  = 9'd5;
    localparam logic [7:0] THRESHOLD_RST    = 8'd24;

    // result item layout
    localparam int INDEX_W = 32;
    localparam int OUT_W   = 40;

    typedef struct packed {
        logic [8:0] short_window;
        logic [8:0] long_window;
        logic [7:0] threshold_q4;
        logic       touched;
    } stl_cfg_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SWEEP = 6'b000010,
        ST_SUM   = 6'b000100,
        ST_MUL1  = 6'b001000,
        ST_MUL2  = 6'b010000,
        ST_OUT   = 6'b100000
    } stl_state_t;

endpackage

`default_nettype wire

>>> hdl/sta_lta_energy_trigger_unit.sv
// top level of the sta/lta energy trigger
// an accepted sample passes the queue, then the sum, multiply and output states of the back end
// the back end takes a new sample only once the last one has passed the sum, two multiply
//   stages and the result register, and it waits in the output state while a result is stalled
// after a window register write the new sample waits while the sums are rebuilt from the
//   square history
// reset: asynchronous, active low; clears control, sums and count; history reads as empty
`default_nettype none

module sta_lta_energy_trigger_unit #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // sample stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,   // sample
    // result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic      [stl_pkg::OUT_W-1:0]          m_axis_tdata,   // decided, event_res, sample_index
    // configuration writes
    input  wire logic                               cfg_we,
    input  wire logic [stl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [stl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int IN_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SQ_W = 2 * SAMPLE_BITS - 1;

    // configuration registers, kept raw; the back end clamps the windows
    logic [8:0] short_window_reg;
    logic [8:0] long_window_reg;
    logic [7:0] threshold_reg;

    stl_pkg::stl_cfg_t cfg;

    // handshake between front end, queue and back end
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;
    logic [SQ_W-1:0] front_square;
    logic [SQ_W-1:0] q_square;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_window_reg <= stl_pkg::SHORT_WINDOW_RST;
            long_window_reg  <= stl_pkg::LONG_WINDOW_RST;
            threshold_reg    <= stl_pkg::THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                stl_pkg::CFG_SHORT_WINDOW: short_window_reg <= cfg_wdata;
                stl_pkg::CFG_LONG_WINDOW:  long_window_reg  <= cfg_wdata;
                stl_pkg::CFG_THRESHOLD:    threshold_reg    <= cfg_wdata[7:0];
                default:                   ;
            endcase
        end
    end

    assign cfg.short_window = short_window_reg;
    assign cfg.long_window  = long_window_reg;
    assign cfg.threshold_q4 = threshold_reg;
    // window writes force a rebuild of the running sums before the next item
    assign cfg.touched      = cfg_we && ((cfg_addr == stl_pkg::CFG_SHORT_WINDOW) ||
                                         (cfg_addr == stl_pkg::CFG_LONG_WINDOW));

    // front end: sign handling and squaring
    stl_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_W        (IN_W)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_square      (front_square)
    );

    // two-entry queue; sample intake waits on a stalled result once both entries are full
    stl_fifo #(
        .WIDTH (SQ_W),
        .DEPTH (2)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_square),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_square)
    );

    // back end: history, window sums, cross-multiplied ratio test
    stl_back #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_square      (q_square),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> hdl/stl_ram.sv
// generic single-write, single-read ram with registered read
`default_nettype none

module stl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read of the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/stl_front.sv
// front end: takes samples and turns them into squared magnitudes
`default_nettype none

module stl_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int IN_W        = 16
) (
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [IN_W-1:0]            s_axis_tdata,
    input  wire logic                       q_full,
    output logic                            q_push,
    output logic      [2*SAMPLE_BITS-2:0]   q_square
);

    localparam int SQ_FULL_W = 2 * SAMPLE_BITS;

    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ_FULL_W-1:0]   sq_full;

    // bits above the sign bit are ignored
    assign raw = s_axis_tdata[SAMPLE_BITS-1:0];
    assign mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

    // the square of the most negative sample is 2^(2n-2), so one bit less suffices
    assign sq_full  = SQ_FULL_W'(mag) * SQ_FULL_W'(mag);
    assign q_square = sq_full[SQ_FULL_W-2:0];

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

endmodule

`default_nettype wire

>>> hdl/stl_fifo.sv
// small register queue between front and back end
`default_nettype none

module stl_fifo #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic      [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/stl_back.sv
// back end: square history, running window sums, ratio test and result register
`default_nettype none

module stl_back #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire stl_pkg::stl_cfg_t             cfg,
    input  wire logic                          q_valid,
    input  wire logic [2*SAMPLE_BITS-2:0]      q_square,
    output logic                               q_pop,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [stl_pkg::OUT_W-1:0]     m_axis_tdata
);

    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int WW    = $clog2(WINDOW_MAX + 1);
    localparam int SA_W  = WW + 1;
    localparam int EXT_W = AW + 2;
    localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W = SQ_W + WW;
    localparam int PS_W  = SUM_W + WW;
    localparam int TS_W  = 8 + WW;
    localparam int RHS_W = SUM_W + TS_W;
    localparam int PAD_W = stl_pkg::OUT_W - stl_pkg::INDEX_W - 2;

    localparam logic [AW-1:0]    HEAD_LAST = AW'(WINDOW_MAX - 1);
    localparam logic [WW-1:0]    FILL_MAX  = WW'(WINDOW_MAX);
    localparam logic [EXT_W-1:0] WM_EXT    = EXT_W'(WINDOW_MAX);

    function automatic logic [WW-1:0] clamp_window(input logic [8:0] w);
        logic [31:0] wide;
        wide = {23'd0, w};
        if (wide == 32'd0)
        begin
            wide = 32'd1;
        end
        else if (wide > 32'(WINDOW_MAX))
        begin
            wide = 32'(WINDOW_MAX);
        end
        return wide[WW-1:0];
    endfunction

    // slot holding the square that is age samples old (age 1 is the newest)
    function automatic logic [AW-1:0] age_addr(input logic [AW-1:0] hd,
                                               input logic [WW-1:0] age);
        logic [EXT_W-1:0] t;
        t = EXT_W'(hd) + WM_EXT - EXT_W'(age);
        if (t >= WM_EXT)
        begin
            t = t - WM_EXT;
        end
        return t[AW-1:0];
    endfunction

    stl_pkg::stl_state_t state_reg;

    logic [AW-1:0]    head_reg;
    logic [WW-1:0]    fill_reg;
    logic [SUM_W-1:0] short_sum_reg;
    logic [SUM_W-1:0] long_sum_reg;
    logic [31:0]      count_reg;
    logic             dirty_reg;
    logic [SA_W-1:0]  sweep_age_reg;
    logic [WW-1:0]    pend_age_reg;
    logic             pend_reg;
    logic             out_valid_reg;

    logic [31:0]               idx_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic                      decided_reg;
    logic                      drop_s_reg;
    logic                      drop_l_reg;
    logic [PS_W-1:0]           prod_s_reg;
    logic [TS_W-1:0]           thr_sw_reg;
    logic [RHS_W-1:0]          rhs_reg;
    logic [stl_pkg::OUT_W-1:0] out_data_reg;

    logic [WW-1:0]    sw;
    logic [WW-1:0]    lw;
    logic [WW-1:0]    maxw;
    logic [WW-1:0]    need;
    logic             start_step;
    logic             start_sweep;
    logic             sweep_issue;
    logic             sweep_done;
    logic             out_free;
    logic             sums_zero;
    logic             event_hit;
    logic [RHS_W-1:0] lhs;
    logic [AW-1:0]    raddr_a;
    logic [AW-1:0]    raddr_b;
    logic [SQ_W-1:0]  rd_a;
    logic [SQ_W-1:0]  rd_b;

    assign sw   = clamp_window(cfg.short_window);
    assign lw   = clamp_window(cfg.long_window);
    assign maxw = (sw > lw) ? sw : lw;
    assign need = maxw - 1'b1;

    assign start_step  = (state_reg == stl_pkg::ST_IDLE) && q_valid && !dirty_reg;
    assign start_sweep = (state_reg == stl_pkg::ST_IDLE) && q_valid && dirty_reg;
    assign sweep_issue = (state_reg == stl_pkg::ST_SWEEP) && (sweep_age_reg <= SA_W'(maxw));
    assign sweep_done  = (state_reg == stl_pkg::ST_SWEEP) && !sweep_issue && !pend_reg;
    assign out_free    = !out_valid_reg || m_axis_tready;
    assign q_pop       = start_step;

    // copy a serves the short window and the rebuild sweep, copy b the long window
    assign raddr_a = (state_reg == stl_pkg::ST_SWEEP) ? age_addr(head_reg, sweep_age_reg[WW-1:0])
                                                      : age_addr(head_reg, sw);
    assign raddr_b = age_addr(head_reg, lw);

    stl_ram #(
        .WIDTH (SQ_W),
        .DEPTH (WINDOW_MAX)
    ) u_hist_a (
        .clk   (clk),
        .we    (start_step),
        .waddr (head_reg),
        .wdata (q_square),
        .raddr (raddr_a),
        .rdata (rd_a)
    );

    stl_ram #(
        .WIDTH (SQ_W),
        .DEPTH (WINDOW_MAX)
    ) u_hist_b (
        .clk   (clk),
        .we    (start_step),
        .waddr (head_reg),
        .wdata (q_square),
        .raddr (raddr_b),
        .rdata (rd_b)
    );

    assign sums_zero = (short_sum_reg == '0) && (long_sum_reg == '0);
    assign lhs       = RHS_W'({prod_s_reg, 4'b0000});
    assign event_hit = decided_reg && !sums_zero && (lhs >= rhs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stl_pkg::ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
            count_reg     <= '0;
            dirty_reg     <= 1'b0;
            sweep_age_reg <= '0;
            pend_age_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                stl_pkg::ST_IDLE:
                begin
                    if (start_sweep)
                    begin
                        short_sum_reg <= '0;
                        long_sum_reg  <= '0;
                        sweep_age_reg <= SA_W'(1);
                        pend_reg      <= 1'b0;
                        state_reg     <= stl_pkg::ST_SWEEP;
                    end
                    else if (start_step)
                    begin
                        head_reg  <= (head_reg == HEAD_LAST) ? '0 : head_reg + 1'b1;
                        fill_reg  <= (fill_reg == FILL_MAX) ? fill_reg : fill_reg + 1'b1;
                        count_reg <= count_reg + 32'd1;
                        state_reg <= stl_pkg::ST_SUM;
                    end
                end

                stl_pkg::ST_SWEEP:
                begin
                    if (sweep_issue)
                    begin
                        pend_age_reg  <= sweep_age_reg[WW-1:0];
                        pend_reg      <= 1'b1;
                        sweep_age_reg <= sweep_age_reg + 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    // slots never written count as zero
                    if (pend_reg && (pend_age_reg <= fill_reg))
                    begin
                        if (pend_age_reg <= sw)
                        begin
                            short_sum_reg <= short_sum_reg + SUM_W'(rd_a);
                        end
                        if (pend_age_reg <= lw)
                        begin
                            long_sum_reg <= long_sum_reg + SUM_W'(rd_a);
                        end
                    end
                    if (sweep_done)
                    begin
                        state_reg <= stl_pkg::ST_IDLE;
                    end
                end

                stl_pkg::ST_SUM:
                begin
                    short_sum_reg <= short_sum_reg + SUM_W'(sq_reg)
                                     - (drop_s_reg ? SUM_W'(rd_a) : '0);
                    long_sum_reg  <= long_sum_reg + SUM_W'(sq_reg)
                                     - (drop_l_reg ? SUM_W'(rd_b) : '0);
                    state_reg     <= stl_pkg::ST_MUL1;
                end

                stl_pkg::ST_MUL1:
                begin
                    state_reg <= stl_pkg::ST_MUL2;
                end

                stl_pkg::ST_MUL2:
                begin
                    state_reg <= stl_pkg::ST_OUT;
                end

                stl_pkg::ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= stl_pkg::ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= stl_pkg::ST_IDLE;
                end
            endcase

            // result register: loaded from the last stage, cleared once taken
            if ((state_reg == stl_pkg::ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // a window register write invalidates the running sums
            if (cfg.touched)
            begin
                dirty_reg <= 1'b1;
            end
            else if (sweep_done)
            begin
                dirty_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_step)
        begin
            sq_reg      <= q_square;
            idx_reg     <= count_reg;
            decided_reg <= (count_reg >= 32'(need));
            drop_s_reg  <= (sw <= fill_reg);
            drop_l_reg  <= (lw <= fill_reg);
        end
        if (state_reg == stl_pkg::ST_MUL1)
        begin
            prod_s_reg <= PS_W'(short_sum_reg) * PS_W'(lw);
            thr_sw_reg <= TS_W'(cfg.threshold_q4) * TS_W'(sw);
        end
        if (state_reg == stl_pkg::ST_MUL2)
        begin
            rhs_reg <= RHS_W'(long_sum_reg) * RHS_W'(thr_sw_reg);
        end
        if ((state_reg == stl_pkg::ST_OUT) && out_free)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, idx_reg, event_hit, decided_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> hdl/stl_checker.sv
// port-level checks of the trigger and their binding to the top level
`default_nettype none

module stl_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [stl_pkg::OUT_W-1:0]      m_axis_tdata
);

    logic        in_acc;
    logic        out_acc;
    logic [31:0] exp_idx_reg;
    logic [3:0]  pending_reg;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (out_acc)
            begin
                exp_idx_reg <= exp_idx_reg + 32'd1;
            end
            if (in_acc && !out_acc)
            begin
                pending_reg <= pending_reg + 4'd1;
            end
            else if (out_acc && !in_acc)
            begin
                pending_reg <= pending_reg - 4'd1;
            end
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an event is only flagged with a decision
    a_event_decided: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] || !m_axis_tdata[1]))
        else $error("event without decision");

    // indexes run in order with none skipped
    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (m_axis_tdata[33:2] == exp_idx_reg))
        else $error("sample index out of order");

    // no result without a sample behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (pending_reg != 4'd0) || in_acc)
        else $error("result without sample");

    // result channel idle once reset has been applied
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

endmodule

bind sta_lta_energy_trigger_unit stl_checker u_stl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> tb/sta_lta_energy_trigger_unit_tb.sv
// self-checking testbench of the sta/lta energy trigger with a cycle-free trigger predictor
`default_nettype none

module sta_lta_energy_trigger_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH     = 256;
    localparam int WATCHDOG_LIMIT = 4000;   // rebuild after a window write plus long stalls
    localparam int TAIL_CYCLES    = 24;     // result latency plus some slack

    // one predicted result item
    typedef struct {
        logic        decided;
        logic        event_res;
        logic [31:0] sample_index;
    } trigger_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // sample stream toward the block
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;        // sample

    // result stream from the block
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [stl_pkg::OUT_W-1:0] m_axis_tdata;    // decided, event_res, sample_index

    // configuration writes
    logic                           cfg_we    = 1'b0;
    logic [stl_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [stl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    sta_lta_energy_trigger_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // trigger predictor: own copy of the square history, count and registers
    // ------------------------------------------------------------------
    logic [30:0] square_hist [HIST_DEPTH];
    int unsigned hist_head  = 0;
    logic [31:0] seen_count = '0;
    logic [8:0]  short_len  = stl_pkg::SHORT_WINDOW_RST;
    logic [8:0]  long_len   = stl_pkg::LONG_WINDOW_RST;
    logic [7:0]  ratio_q4   = stl_pkg::THRESHOLD_RST;

    initial
    begin
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            square_hist[i] = '0;
        end
    end

    // zero means one sample, anything past the history depth saturates
    function automatic int unsigned clamp_len(logic [8:0] w);
        if (w == 9'd0)
            return 1;
        if (w > 9'(HIST_DEPTH))
            return HIST_DEPTH;
        return int'(w);
    endfunction

    // sum of the newest w squares, the newest one included
    function automatic logic [63:0] energy_sum(int unsigned w);
        logic [63:0] acc;
        int unsigned pos;
        acc = '0;
        pos = hist_head;
        for (int unsigned k = 0; k < w; k++)
        begin
            pos = (pos == 0) ? HIST_DEPTH - 1 : pos - 1;
            acc += 64'(square_hist[pos]);
        end
        return acc;
    endfunction

    function automatic trigger_t predict_trigger(logic [15:0] raw);
        logic [15:0] mag;
        logic [31:0] prod;
        int unsigned sw;
        int unsigned lw;
        int unsigned need;
        logic [63:0] short_e;
        logic [63:0] long_e;
        logic [63:0] lhs;
        logic [63:0] rhs;
        trigger_t    r;
        mag  = raw[15] ? (~raw + 16'd1) : raw;
        prod = {16'd0, mag} * {16'd0, mag};
        sw   = clamp_len(short_len);
        lw   = clamp_len(long_len);
        need = ((sw > lw) ? sw : lw) - 1;

        r.sample_index = seen_count;
        r.decided      = (seen_count >= 32'(need));
        r.event_res    = 1'b0;

        square_hist[hist_head] = prod[30:0];
        hist_head = (hist_head + 1 >= HIST_DEPTH) ? 0 : hist_head + 1;

        short_e = energy_sum(sw);
        long_e  = energy_sum(lw);

        // cross-multiplied means, both sums zero never triggers
        if (r.decided && !(short_e == 0 && long_e == 0))
        begin
            lhs = 64'd16 * short_e * 64'(lw);
            rhs = 64'(ratio_q4) * long_e * 64'(sw);
            r.event_res = (lhs >= rhs);
        end

        seen_count = seen_count + 32'd1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // shared bookkeeping
    // ------------------------------------------------------------------
    logic [15:0] sample_q [$];          // samples waiting for the driver
    trigger_t    pending_triggers [$];  // predicted results not yet seen
    int          mismatch_count = 0;
    int          samples_sent   = 0;
    int          results_seen   = 0;
    int          events_seen    = 0;
    int          decided_seen   = 0;
    int          setting_count  = 0;
    bit          tx_steady      = 1'b0; // no sender gaps while set
    bit          rx_steady      = 1'b0; // no receiver stalls while set

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // driver: presents queued samples, predicts each accepted item
    // ------------------------------------------------------------------
    int unsigned tx_gap = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            tx_gap        <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                pending_triggers.push_back(predict_trigger(s_axis_tdata));
                samples_sent++;
            end
            // the slot is free when nothing is shown or it was just taken
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap        <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (sample_q.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= sample_q.pop_front();
                    tx_gap        <= tx_steady ? 0 : pick_gap();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random back-pressure, checks results against the oldest prediction
    // ------------------------------------------------------------------
    int unsigned rx_stall = 0;

    always @(posedge clk)
    begin
        trigger_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall      <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (m_axis_tdata[1])
                    events_seen++;
                if (m_axis_tdata[0])
                    decided_seen++;
                if (pending_triggers.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result item: decided=%0b event=%0b index=%0d",
                                 m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[33:2]);
                end
                else
                begin
                    want = pending_triggers.pop_front();
                    if (m_axis_tdata[0] !== want.decided ||
                        m_axis_tdata[1] !== want.event_res ||
                        m_axis_tdata[33:2] !== want.sample_index)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch at index %0d: expected decided=%0b event=%0b",
                                     want.sample_index, want.decided, want.event_res,
                                     " index=%0d, got decided=%0b event=%0b index=%0d",
                                     want.sample_index, m_axis_tdata[0], m_axis_tdata[1],
                                     m_axis_tdata[33:2]);
                    end
                end
            end
            if (rx_stall > 0)
            begin
                rx_stall      <= rx_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 99) < 35)
                    rx_stall <= pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: counts cycles without any handshake while work is outstanding
    // ------------------------------------------------------------------
    int stuck_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (sample_q.size() == 0 && !s_axis_tvalid && pending_triggers.size() == 0))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                     stuck_cycles, pending_triggers.size());
            $display("[sta_lta_energy_trigger_unit] ERROR");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // register writes happen only with the block idle, predictor copy follows
    task automatic write_reg(input logic [stl_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [8:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (addr == stl_pkg::CFG_SHORT_WINDOW)
            short_len = value;
        else if (addr == stl_pkg::CFG_LONG_WINDOW)
            long_len = value;
        else if (addr == stl_pkg::CFG_THRESHOLD)
            ratio_q4 = value[7:0];
    endtask

    task automatic set_trigger(input logic [8:0] sw, input logic [8:0] lw, input logic [7:0] thr);
        write_reg(stl_pkg::CFG_SHORT_WINDOW, sw);
        write_reg(stl_pkg::CFG_LONG_WINDOW, lw);
        write_reg(stl_pkg::CFG_THRESHOLD, {1'b0, thr});
        setting_count++;
    endtask

    // wait until every queued sample is taken and every result has come back
    task automatic wait_idle();
        while (sample_q.size() != 0 || s_axis_tvalid || pending_triggers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // window length mix: edges, out of range and ordinary values
    function automatic logic [8:0] pick_window();
        case ($urandom_range(0, 9))
            0: return 9'd0;
            1: return 9'd1;
            2: return 9'd256;
            3: return 9'd511;
            4: return 9'($urandom_range(257, 510));
            5, 6: return 9'($urandom_range(1, 256));
            default: return 9'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [7:0] pick_ratio();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            3: return 8'd16;
            4: return 8'd24;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one sample at a given loudness: silence, hum, moderate, full scale
    function automatic logic [15:0] gen_sample(int unsigned level);
        int v;
        case (level)
            0: v = 0;
            1: v = int'($urandom_range(0, 15)) - 8;
            2: v = int'($urandom_range(0, 4095)) - 2048;
            default:
            begin
                if ($urandom_range(0, 19) == 0)
                    v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
                else
                    v = int'($urandom_range(0, 65535)) - 32768;
            end
        endcase
        return v[15:0];
    endfunction

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned level;
        int unsigned seg_len;
        int unsigned burst_total;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset setting: early samples undecided, then silence with both sums zero
        repeat (6) sample_q.push_back(16'h0000);
        sample_q.push_back(16'h7FFF);
        sample_q.push_back(16'h8000);
        sample_q.push_back(16'hFFFF);
        sample_q.push_back(16'h0001);
        repeat (5) sample_q.push_back(16'h0000);
        wait_idle();

        // short window wider than long, zero threshold: zero long sum with nonzero short sum
        set_trigger(9'd4, 9'd1, 8'd0);
        sample_q.push_back(16'd1000);
        sample_q.push_back(16'h0000);
        sample_q.push_back(16'd5);
        sample_q.push_back(-16'sd5);
        sample_q.push_back(16'h0000);
        sample_q.push_back(16'h0000);
        wait_idle();

        // zero short window and saturated long window, highest threshold
        set_trigger(9'd0, 9'd511, 8'd255);
        sample_q.push_back(16'h8000);
        sample_q.push_back(16'h7FFF);
        sample_q.push_back(16'd3);
        wait_idle();

        // random phases: quiet stretches broken by bursts so the ratio crosses both ways
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase == 0)
                set_trigger(9'd1, 9'd256, 8'd255);
            else if (phase == 1)
                set_trigger(9'd256, 9'd1, 8'd1);
            else if (phase == 2)
                set_trigger(9'd3, 9'd12, 8'd24);
            else
                set_trigger(pick_window(), pick_window(), pick_ratio());
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            burst_total = 0;
            while (burst_total < 95)
            begin
                level   = $urandom_range(0, 3);
                seg_len = $urandom_range(3, 30);
                repeat (seg_len) sample_q.push_back(gen_sample(level));
                burst_total += seg_len;
            end
            wait_idle();
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d samples over %0d register settings", samples_sent, setting_count);
        $display("results checked: %0d, decided: %0d, events: %0d, mismatches: %0d",
                 results_seen, decided_seen, events_seen, mismatch_count);
        if (mismatch_count == 0 && pending_triggers.size() == 0)
            $display("[sta_lta_energy_trigger_unit] OK");
        else
            $display("[sta_lta_energy_trigger_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> sta_lta_energy_trigger_unit.f
hdl/stl_pkg.sv
hdl/stl_ram.sv
hdl/stl_front.sv
hdl/stl_fifo.sv
hdl/stl_back.sv
hdl/sta_lta_energy_trigger_unit.sv
hdl/stl_checker.sv
tb/sta_lta_energy_trigger_unit_tb.sv
